// ----- hw/rtl/bvam_pkg.sv -----
`timescale 1ns / 1ps

package bvam_pkg;

	localparam int OP_W       = 3;
	localparam int INDEX_W    = 13;
	localparam int PARENT_W   = 12;
	localparam int VIEW_W     = 13;
	localparam int CUR_VIEW_W = 14;
	localparam int MARKS_W    = 13;
	localparam int STAMP_W    = 32;
	localparam int EXT_W      = 17;

	localparam int LEAF_COUNT_DEF = 8192;
	localparam int NODE_COUNT_DEF = 4096;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_LEAF  = 3'd0,
		OP_LOAD_NODE  = 3'd1,
		OP_BEGIN      = 3'd2,
		OP_MARK       = 3'd3,
		OP_QUERY_LEAF = 3'd4,
		OP_QUERY_NODE = 3'd5
	} op_t;

endpackage

// ----- hw/rtl/bvam_ram.sv -----
`timescale 1ns / 1ps

module bvam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/bsp_visible_ancestor_marker_unit.sv -----
`timescale 1ns / 1ps

// Visible-ancestor marker for a BSP tree. Items are taken while busy is low;
// every item gives exactly one result, shown for one cycle with done high, and
// the receiver cannot stall it. A load writes the parent memory, if its index
// is in range, in the dispatch state and returns to idle. A begin-frame that
// starts a frame goes from dispatch to the begin check, and an in-range query
// once a frame has started to the query check; any other begin-frame, query or
// unused op ends in dispatch. An ignored mark ends in dispatch; any other mark
// goes on to the leaf check and then reads one ancestor node per cycle,
// including the already stamped node where it stops; the walk is set by the
// registered read of the node stamp and parent memories. After reset the block
// sweeps both stamp memories to zero, one entry a cycle, over max(LEAF_COUNT,
// NODE_COUNT) addresses with busy high; lock_visibility writes on cfg_we are taken at any time.
module bsp_visible_ancestor_marker_unit #(
	parameter int LEAF_COUNT = bvam_pkg::LEAF_COUNT_DEF,
	parameter int NODE_COUNT = bvam_pkg::NODE_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [bvam_pkg::OP_W-1:0]      op,
	input  logic [bvam_pkg::INDEX_W-1:0]   index,
	input  logic [bvam_pkg::PARENT_W-1:0]  parent,
	input  logic [bvam_pkg::VIEW_W-1:0]    view_leaf,
	input  logic                           cfg_we,
	input  logic                           cfg_data,
	output logic                           done,
	output logic                           visible,
	output logic                           frame_started,
	output logic [bvam_pkg::MARKS_W-1:0]   new_marks
);

	import bvam_pkg::*;

	localparam int LAW = $clog2(LEAF_COUNT);
	localparam int NAW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CW  = $clog2(NODE_COUNT + 2);
	localparam int CLR_COUNT = (LEAF_COUNT > NODE_COUNT) ? LEAF_COUNT : NODE_COUNT;
	localparam int CLW = $clog2(CLR_COUNT);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DISPATCH,
		ST_LEAF_CHK,
		ST_WALK_CHK,
		ST_BEGIN_CHK,
		ST_QUERY_CHK
	} state_t;

	state_t                state_q;
	op_t                   op_q;
	logic [INDEX_W-1:0]    index_q;
	logic [PARENT_W-1:0]   parent_q;
	logic [VIEW_W-1:0]     view_q;
	logic [CW-1:0]         count_q;
	logic [NAW-1:0]        node_q;
	logic [STAMP_W-1:0]    frame_q;
	logic [CUR_VIEW_W-1:0] cur_view_q;
	logic                  mark_en_q;
	logic                  lock_q;
	logic [CLW-1:0]        clr_q;
	logic                  done_q;
	logic                  visible_q;
	logic                  started_q;
	logic [MARKS_W-1:0]    marks_q;

	logic [EXT_W-1:0]      idx_ext;
	logic [EXT_W-1:0]      clr_ext;
	logic [EXT_W-1:0]      walk_src;
	logic                  idx_leaf_ok;
	logic                  idx_node_ok;
	logic                  walk_ok;
	logic [NAW-1:0]        walk_addr;
	logic [STAMP_W-1:0]    frame_next;
	logic [CW-1:0]         count_inc;
	logic [31:0]           count_wide;
	logic [31:0]           count_cur_wide;

	logic                  ls_we, lp_we, ns_we, np_we;
	logic [LAW-1:0]        ls_waddr, leaf_addr;
	logic [NAW-1:0]        ns_waddr, node_raddr, node_idx_addr;
	logic [STAMP_W-1:0]    ls_wdata, ns_wdata, ls_rdata, ns_rdata;
	logic [PARENT_W-1:0]   lp_rdata, np_rdata;

	assign idx_ext       = {{(EXT_W-INDEX_W){1'b0}}, index_q};
	assign clr_ext       = {{(EXT_W-CLW){1'b0}}, clr_q};
	assign idx_leaf_ok   = idx_ext < EXT_W'(LEAF_COUNT);
	assign idx_node_ok   = idx_ext < EXT_W'(NODE_COUNT);
	assign leaf_addr     = idx_ext[LAW-1:0];
	assign node_idx_addr = idx_ext[NAW-1:0];

	assign walk_src  = (state_q == ST_WALK_CHK) ? {{(EXT_W-PARENT_W){1'b0}}, np_rdata}
	                                            : {{(EXT_W-PARENT_W){1'b0}}, lp_rdata};
	assign walk_ok   = (walk_src != '0) && (walk_src < EXT_W'(NODE_COUNT));
	assign walk_addr = walk_src[NAW-1:0];

	assign frame_next     = ((frame_q + 1'b1) == '0) ? STAMP_W'(1) : frame_q + 1'b1;
	assign count_inc      = count_q + 1'b1;
	assign count_wide     = {{(32-CW){1'b0}}, count_inc};
	assign count_cur_wide = {{(32-CW){1'b0}}, count_q};

	always_comb begin
		ls_we      = 1'b0;
		ls_waddr   = leaf_addr;
		ls_wdata   = frame_q;
		lp_we      = 1'b0;
		ns_we      = 1'b0;
		ns_waddr   = node_q;
		ns_wdata   = frame_q;
		np_we      = 1'b0;
		node_raddr = node_idx_addr;
		unique case (state_q)
			ST_CLEAR: begin
				ls_we    = clr_ext < EXT_W'(LEAF_COUNT);
				ls_waddr = clr_ext[LAW-1:0];
				ls_wdata = '0;
				ns_we    = clr_ext < EXT_W'(NODE_COUNT);
				ns_waddr = clr_ext[NAW-1:0];
				ns_wdata = '0;
			end
			ST_DISPATCH: begin
				lp_we = (op_q == OP_LOAD_LEAF) && idx_leaf_ok;
				np_we = (op_q == OP_LOAD_NODE) && idx_node_ok;
				if (op_q == OP_BEGIN) begin
					node_raddr = '0;
				end
			end
			ST_LEAF_CHK: begin
				ls_we      = ls_rdata != frame_q;
				node_raddr = walk_addr;
			end
			ST_WALK_CHK: begin
				ns_we      = ns_rdata != frame_q;
				node_raddr = walk_addr;
			end
			ST_BEGIN_CHK: begin
				ns_we    = ns_rdata != frame_q;
				ns_waddr = '0;
			end
			default: begin
			end
		endcase
	end

	bvam_ram #(.WIDTH(STAMP_W), .DEPTH(LEAF_COUNT)) u_leaf_stamp (
		.clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
		.raddr(leaf_addr), .rdata(ls_rdata)
	);

	bvam_ram #(.WIDTH(PARENT_W), .DEPTH(LEAF_COUNT)) u_leaf_parent (
		.clk(clk), .we(lp_we), .waddr(leaf_addr), .wdata(parent_q),
		.raddr(leaf_addr), .rdata(lp_rdata)
	);

	bvam_ram #(.WIDTH(STAMP_W), .DEPTH(NODE_COUNT)) u_node_stamp (
		.clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
		.raddr(node_raddr), .rdata(ns_rdata)
	);

	bvam_ram #(.WIDTH(PARENT_W), .DEPTH(NODE_COUNT)) u_node_parent (
		.clk(clk), .we(np_we), .waddr(node_idx_addr), .wdata(parent_q),
		.raddr(node_raddr), .rdata(np_rdata)
	);

	// hold the accepted transaction
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q     <= op_t'(op);
			index_q  <= index;
			parent_q <= parent;
			view_q   <= view_leaf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= 1'b0;
		end else if (cfg_we) begin
			lock_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			count_q    <= '0;
			node_q     <= '0;
			frame_q    <= '0;
			cur_view_q <= '1;
			mark_en_q  <= 1'b0;
			done_q     <= 1'b0;
			visible_q  <= 1'b0;
			started_q  <= 1'b0;
			marks_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLW'(CLR_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					visible_q <= 1'b0;
					started_q <= 1'b0;
					marks_q   <= '0;
					state_q   <= ST_IDLE;
					done_q    <= 1'b1;
					unique case (op_q)
						OP_BEGIN: begin
							if (!lock_q && ({1'b0, view_q} != cur_view_q)) begin
								cur_view_q <= {1'b0, view_q};
								frame_q    <= frame_next;
								mark_en_q  <= 1'b1;
								started_q  <= 1'b1;
								state_q    <= ST_BEGIN_CHK;
								done_q     <= 1'b0;
							end else begin
								mark_en_q <= 1'b0;
							end
						end
						OP_MARK: begin
							if (mark_en_q && (index_q != '0) && idx_leaf_ok) begin
								state_q <= ST_LEAF_CHK;
								done_q  <= 1'b0;
							end
						end
						OP_QUERY_LEAF: begin
							if (idx_leaf_ok && (frame_q != '0)) begin
								state_q <= ST_QUERY_CHK;
								done_q  <= 1'b0;
							end
						end
						OP_QUERY_NODE: begin
							if (idx_node_ok && (frame_q != '0)) begin
								state_q <= ST_QUERY_CHK;
								done_q  <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				ST_BEGIN_CHK: begin
					marks_q <= (ns_rdata != frame_q) ? MARKS_W'(1) : '0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_QUERY_CHK: begin
					if (op_q == OP_QUERY_LEAF) begin
						visible_q <= ls_rdata == frame_q;
					end else begin
						visible_q <= ns_rdata == frame_q;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_LEAF_CHK: begin
					if (ls_rdata == frame_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						count_q <= CW'(1);
						if (walk_ok) begin
							node_q  <= walk_addr;
							state_q <= ST_WALK_CHK;
						end else begin
							marks_q <= MARKS_W'(1);
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_WALK_CHK: begin
					if (ns_rdata == frame_q) begin
						marks_q <= count_cur_wide[MARKS_W-1:0];
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						count_q <= count_inc;
						// a self-parent was just stamped: stop
						if (walk_ok && (walk_addr != node_q)) begin
							node_q <= walk_addr;
						end else begin
							marks_q <= count_wide[MARKS_W-1:0];
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = state_q != ST_IDLE;
	assign done          = done_q;
	assign visible       = visible_q;
	assign frame_started = started_q;
	assign new_marks     = marks_q;

endmodule

// ----- bench/bvam_marker_checker.sv -----
`timescale 1ns / 1ps

module bvam_marker_checker #(
	parameter int LEAF_COUNT = bvam_pkg::LEAF_COUNT_DEF,
	parameter int NODE_COUNT = bvam_pkg::NODE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [bvam_pkg::OP_W-1:0]     op,
	input  logic [bvam_pkg::INDEX_W-1:0]  index,
	input  logic [bvam_pkg::PARENT_W-1:0] parent,
	input  logic [bvam_pkg::VIEW_W-1:0]   view_leaf,
	input  logic                          cfg_we,
	input  logic                          cfg_data,
	input  logic                          done,
	input  logic                          visible,
	input  logic                          frame_started,
	input  logic [bvam_pkg::MARKS_W-1:0]  new_marks,
	output int                            fail_count,
	output int                            pending
);
	import bvam_pkg::*;

	typedef struct packed {
		logic               visible;
		logic               frame_started;
		logic [MARKS_W-1:0] new_marks;
	} outcome_t;

	logic [PARENT_W-1:0]   leaf_up   [LEAF_COUNT];
	logic [PARENT_W-1:0]   node_up   [NODE_COUNT];
	logic [STAMP_W-1:0]    leaf_seen [LEAF_COUNT];
	logic [STAMP_W-1:0]    node_seen [NODE_COUNT];
	logic [STAMP_W-1:0]    frame_no;
	logic [CUR_VIEW_W-1:0] view_now;
	logic                  marking_on;
	logic                  lock_now;
	outcome_t              outcomes_due [$];
	outcome_t              want;
	int                    errors = 0;

	assign fail_count = errors;

	task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
		if (errors < 50)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
		errors++;
	endtask

	function automatic logic [MARKS_W-1:0] stamp_ancestors(input logic [INDEX_W-1:0] leaf);
		int at;
		int n;
		if (leaf_seen[leaf] == frame_no)
			return '0;
		leaf_seen[leaf] = frame_no;
		n = 1;
		at = int'(leaf_up[leaf]);
		for (int steps = 0; steps <= NODE_COUNT; steps++) begin
			if (at == 0 || at >= NODE_COUNT)
				break;
			if (node_seen[at] == frame_no)
				break;
			node_seen[at] = frame_no;
			n++;
			at = int'(node_up[at]);
		end
		return MARKS_W'(n);
	endfunction

	function automatic outcome_t mark_outcome(input logic [OP_W-1:0] code,
			input logic [INDEX_W-1:0] idx, input logic [PARENT_W-1:0] par,
			input logic [VIEW_W-1:0] view);
		outcome_t r;
		r = '0;
		case (code)
		OP_LOAD_LEAF: if (idx < LEAF_COUNT) leaf_up[idx] = par;
		OP_LOAD_NODE: if (idx < NODE_COUNT) node_up[idx] = par;
		OP_BEGIN: begin
			if (!lock_now && view_now != CUR_VIEW_W'(view)) begin
				view_now = CUR_VIEW_W'(view);
				frame_no = frame_no + 1'b1;
				if (frame_no == '0)
					frame_no = STAMP_W'(1);
				r.frame_started = 1'b1;
				marking_on = 1'b1;
				if (node_seen[0] != frame_no) begin
					node_seen[0] = frame_no;
					r.new_marks = MARKS_W'(1);
				end
			end else begin
				marking_on = 1'b0;
			end
		end
		OP_MARK: begin
			if (marking_on && idx != 0 && idx < LEAF_COUNT)
				r.new_marks = stamp_ancestors(idx);
		end
		OP_QUERY_LEAF: begin
			if (idx < LEAF_COUNT && frame_no != '0)
				r.visible = (leaf_seen[idx] == frame_no);
		end
		OP_QUERY_NODE: begin
			if (idx < NODE_COUNT && frame_no != '0)
				r.visible = (node_seen[idx] == frame_no);
		end
		default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEAF_COUNT; i++)
				leaf_seen[i] = '0;
			for (int i = 0; i < NODE_COUNT; i++)
				node_seen[i] = '0;
			frame_no = '0;
			view_now = '1;
			marking_on = 1'b0;
			lock_now = 1'b0;
			outcomes_due.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (outcomes_due.size() == 0) begin
					report("result with nothing pending", 32'd0, 32'd1);
				end else begin
					want = outcomes_due.pop_front();
					if (visible !== want.visible)
						report("visible", 32'(want.visible), 32'(visible));
					if (frame_started !== want.frame_started)
						report("frame_started", 32'(want.frame_started), 32'(frame_started));
					if (new_marks !== want.new_marks)
						report("new_marks", 32'(want.new_marks), 32'(new_marks));
				end
			end
			if (cfg_we)
				lock_now = cfg_data;
			if (start && !busy)
				outcomes_due.insert(outcomes_due.size(),
					mark_outcome(op, index, parent, view_leaf));
			pending <= outcomes_due.size();
		end
	end

endmodule

// ----- bench/tb_bsp_visible_ancestor_marker_unit.sv -----
`timescale 1ns / 1ps

module tb_bsp_visible_ancestor_marker_unit;
	import bvam_pkg::*;

	localparam int LEAF_COUNT    = LEAF_COUNT_DEF;
	localparam int NODE_COUNT    = NODE_COUNT_DEF;
	localparam int INDEX_MAX     = (1 << INDEX_W) - 1;
	localparam int PARENT_MAX    = (1 << PARENT_W) - 1;
	localparam int VIEW_MAX      = (1 << VIEW_W) - 1;
	localparam int CYCLE_LIMIT   = 10_000_000;
	localparam int SETTLE_CYCLES = 64;

	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                start         = 1'b0;
	logic [OP_W-1:0]     op            = '0;
	logic [INDEX_W-1:0]  index         = '0;
	logic [PARENT_W-1:0] parent        = '0;
	logic [VIEW_W-1:0]   view_leaf     = '0;
	logic                cfg_we        = 1'b0;
	logic                cfg_data      = 1'b0;
	logic                busy;
	logic                done;
	logic                visible;
	logic                frame_started;
	logic [MARKS_W-1:0]  new_marks;
	int                  fail_count;
	int                  pending;

	int   cycles   = 0;
	int   issued   = 0;
	int   cur_view = -1;
	logic lock_set = 1'b0;
	bit   leaf_known [LEAF_COUNT];
	bit   node_known [NODE_COUNT];
	int   leaf_pool [$];
	int   node_pool [$];

	always #2 clk = ~clk;

	bsp_visible_ancestor_marker_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.index         (index),
		.parent        (parent),
		.view_leaf     (view_leaf),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.done          (done),
		.visible       (visible),
		.frame_started (frame_started),
		.new_marks     (new_marks)
	);

	bvam_marker_checker marker_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.index         (index),
		.parent        (parent),
		.view_leaf     (view_leaf),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.done          (done),
		.visible       (visible),
		.frame_started (frame_started),
		.new_marks     (new_marks),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send(input logic [OP_W-1:0] code, input int idx, input int par,
			input int view, input bit quiet);
		int pick;
		int gap;
		start <= 1'b1;
		op <= code;
		index <= INDEX_W'(idx);
		parent <= PARENT_W'(par);
		view_leaf <= VIEW_W'(view);
		@(posedge clk);
		while (busy) @(posedge clk);
		if (code <= OP_QUERY_NODE)
			issued++;
		if (code == OP_BEGIN && !lock_set && view != cur_view)
			cur_view = view;
		pick = $urandom_range(0, 99);
		if (quiet || pick < 55)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_lock(input logic value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		lock_set = value;
	endtask

	// parents are zero or come from written nodes, so no walk reads an unwritten entry
	function automatic int safe_parent();
		if (node_pool.size() == 0 || $urandom_range(0, 4) == 0)
			return 0;
		return node_pool[$urandom_range(0, node_pool.size() - 1)];
	endfunction

	function automatic int mark_target();
		if ($urandom_range(0, 11) == 0)
			return 0;
		return leaf_pool[$urandom_range(0, leaf_pool.size() - 1)];
	endfunction

	task automatic load_entry(input bit to_node, input bit quiet);
		int idx;
		int par;
		if (!to_node)
			idx = $urandom_range(0, LEAF_COUNT - 1);
		else if ($urandom_range(0, 9) == 0)
			idx = $urandom_range(0, INDEX_MAX);
		else
			idx = $urandom_range(0, NODE_COUNT - 1);
		// entries never climbed from may take any parent
		if (idx == 0 || (to_node && idx >= NODE_COUNT))
			par = $urandom_range(0, PARENT_MAX);
		else
			par = safe_parent();
		send(to_node ? OP_LOAD_NODE : OP_LOAD_LEAF, idx, par,
			$urandom_range(0, VIEW_MAX), quiet);
		if (idx != 0 && to_node && idx < NODE_COUNT && !node_known[idx]) begin
			node_known[idx] = 1'b1;
			node_pool.insert(node_pool.size(), idx);
		end
		if (idx != 0 && !to_node && !leaf_known[idx]) begin
			leaf_known[idx] = 1'b1;
			leaf_pool.insert(leaf_pool.size(), idx);
		end
	endtask

	task automatic frame_sequence(input bit quiet);
		int view;
		int pick;
		int idx;
		repeat ($urandom_range(0, 3)) load_entry($urandom_range(0, 1) == 1, quiet);
		if (cur_view >= 0 && $urandom_range(0, 6) == 0)
			view = cur_view;
		else
			view = $urandom_range(0, VIEW_MAX);
		send(OP_BEGIN, $urandom_range(0, INDEX_MAX), $urandom_range(0, PARENT_MAX), view, quiet);
		repeat ($urandom_range(2, 16))
			send(OP_MARK, mark_target(), $urandom_range(0, PARENT_MAX),
				$urandom_range(0, VIEW_MAX), quiet);
		repeat ($urandom_range(1, 6)) begin
			pick = $urandom_range(0, 2);
			if ($urandom_range(0, 1)) begin
				idx = (pick != 0) ? leaf_pool[$urandom_range(0, leaf_pool.size() - 1)]
					: $urandom_range(0, INDEX_MAX);
				send(OP_QUERY_LEAF, idx, $urandom_range(0, PARENT_MAX),
					$urandom_range(0, VIEW_MAX), quiet);
			end else begin
				if (pick == 0)
					idx = node_pool[$urandom_range(0, node_pool.size() - 1)];
				else if (pick == 1)
					idx = $urandom_range(0, NODE_COUNT - 1);
				else
					idx = $urandom_range(0, INDEX_MAX);
				send(OP_QUERY_NODE, idx, $urandom_range(0, PARENT_MAX),
					$urandom_range(0, VIEW_MAX), quiet);
			end
		end
	endtask

	task automatic noise_item(input bit quiet);
		logic [OP_W-1:0] code;
		code = OP_W'($urandom_range(0, (1 << OP_W) - 1));
		case (code)
		OP_LOAD_LEAF: load_entry(1'b0, quiet);
		OP_LOAD_NODE: load_entry(1'b1, quiet);
		OP_MARK: send(OP_MARK, mark_target(), $urandom_range(0, PARENT_MAX),
			$urandom_range(0, VIEW_MAX), quiet);
		default: send(code, $urandom_range(0, INDEX_MAX), $urandom_range(0, PARENT_MAX),
			$urandom_range(0, VIEW_MAX), quiet);
		endcase
	endtask

	task automatic run_phase(input logic lock_value, input int item_count);
		int target;
		bit quiet;
		drain();
		write_lock(lock_value);
		target = issued + item_count;
		while (issued < target) begin
			quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 7)
				frame_sequence(quiet);
			else
				repeat ($urandom_range(3, 10)) noise_item(quiet);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		write_lock(1'b0);

		send(OP_QUERY_LEAF, INDEX_MAX, 0, 0, 1'b0);
		send(OP_QUERY_NODE, 0, 0, 0, 1'b0);
		send(OP_LOAD_NODE, 1, 0, 0, 1'b0);
		send(OP_LOAD_NODE, NODE_COUNT - 1, 1, 0, 1'b0);
		send(OP_LOAD_NODE, 0, PARENT_MAX, 0, 1'b0);
		send(OP_LOAD_NODE, INDEX_MAX, 2730, 0, 1'b0);
		send(OP_LOAD_LEAF, INDEX_MAX, NODE_COUNT - 1, 0, 1'b0);
		send(OP_LOAD_LEAF, 1, 1, 0, 1'b0);
		send(OP_LOAD_LEAF, 0, 2730, 0, 1'b0);
		send(OP_MARK, 1, 0, 0, 1'b0);
		send(OP_BEGIN, 0, 0, 0, 1'b0);
		send(OP_MARK, INDEX_MAX, 0, 0, 1'b0);
		send(OP_MARK, 1, 0, 0, 1'b0);
		send(OP_MARK, 1, 0, 0, 1'b0);
		send(OP_MARK, 0, 0, 0, 1'b0);
		send(OP_QUERY_LEAF, INDEX_MAX, 0, 0, 1'b0);
		send(OP_QUERY_LEAF, 2, 0, 0, 1'b0);
		send(OP_QUERY_NODE, NODE_COUNT - 1, 0, 0, 1'b0);
		send(OP_QUERY_NODE, INDEX_MAX, 0, 0, 1'b0);
		send(OP_SPARE_A, INDEX_MAX, PARENT_MAX, VIEW_MAX, 1'b0);
		send(OP_SPARE_B, INDEX_MAX, PARENT_MAX, VIEW_MAX, 1'b0);
		send(OP_BEGIN, 0, 0, 0, 1'b0);
		send(OP_MARK, INDEX_MAX, 0, 0, 1'b0);
		send(OP_BEGIN, 0, 0, VIEW_MAX, 1'b0);
		send(OP_MARK, INDEX_MAX, 0, 0, 1'b0);
		send(OP_QUERY_NODE, 1, 0, 0, 1'b0);

		leaf_known[1] = 1'b1;
		leaf_known[INDEX_MAX] = 1'b1;
		node_known[1] = 1'b1;
		node_known[NODE_COUNT - 1] = 1'b1;
		leaf_pool = '{1, INDEX_MAX};
		node_pool = '{1, NODE_COUNT - 1};

		run_phase(1'b0, 300);
		run_phase(1'b1, 100);
		run_phase(1'b0, 350);
		run_phase(1'b1, 100);
		run_phase(1'b0, 400);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
